FILE: hw/rtl/nma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nma_pkg: shared types and constants for the int8 neuron datapath
// Item layout between the front end, the queue and the back end, plus
// activation mode codes and fixed datapath widths.
// ----------------------------------------------------------------------------
package nma_pkg;

    localparam int DATA_W          = 8;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int ACC_W           = 32;
    localparam int MODE_W          = 2;
    localparam int REQ_SHIFT       = 7;
    localparam int QUOT_W          = ACC_W - REQ_SHIFT;
    localparam int BIASED_W        = QUOT_W + 1;
    localparam int NMA_QUEUE_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELU   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIGN   = 2'd2;

    localparam logic signed [DATA_W-1:0] OUT_MAX = 8'sd127;
    localparam logic signed [DATA_W-1:0] OUT_MIN = -8'sd128;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic signed [DATA_W-1:0] bias;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/nma_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nma_front: input stage
// Takes one weight/activation pair per cycle while o_stall is low, forms the product and holds
// the item until the queue has room.
// ----------------------------------------------------------------------------
module nma_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [nma_pkg::DATA_W-1:0] i_weight,
    input  wire logic signed [nma_pkg::DATA_W-1:0] i_in_value,
    input  wire logic signed [nma_pkg::DATA_W-1:0] i_bias,
    input  wire logic                              i_last,
    output logic                                   o_push,
    output nma_pkg::t_item                         o_item,
    input  nma_pkg::t_q_stat                       i_qstat
);
    import nma_pkg::*;

    logic                     r_vld;
    logic                     n_vld;
    t_item                    r_item;
    logic                     w_take;
    logic signed [PROD_W-1:0] w_prod;

    assign w_prod  = i_weight * i_in_value;
    assign o_stall = r_vld & i_qstat.full;
    assign w_take  = i_valid & ~o_stall;
    assign o_push  = r_vld & ~i_qstat.full;
    assign o_item  = r_item;
    assign n_vld   = w_take | (r_vld & ~o_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.prod <= w_prod;
            r_item.bias <= i_bias;
            r_item.last <= i_last;
        end
    end

`ifndef SYNTH
    // held item must survive a full queue untouched
    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_vld && $stable(r_item))
        else $error("front item lost or altered while queue full");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/nma_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nma_queue: short item queue
// Register-based FIFO between front and back ends; head is read directly.
// ----------------------------------------------------------------------------
module nma_queue #(
    parameter int DEPTH = nma_pkg::NMA_QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  nma_pkg::t_item    i_item,
    input  wire logic         i_pop,
    output nma_pkg::t_item    o_head,
    output nma_pkg::t_q_stat  o_stat
);
    import nma_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full) && !(i_pop && o_stat.empty))
        else $error("queue push when full or pop when empty");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/nma_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nma_back: accumulate and finish
// Adds each product to the accumulator; on the last element requantises,
// biases, clamps and activates into the output register.
// ----------------------------------------------------------------------------
module nma_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  nma_pkg::t_item                         i_head,
    input  nma_pkg::t_q_stat                       i_qstat,
    output logic                                   o_pop,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [nma_pkg::MODE_W-1:0]        i_cfg_data,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [nma_pkg::DATA_W-1:0]      o_neuron_out
);
    import nma_pkg::*;

    logic        [MODE_W-1:0]   r_mode;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;
    logic                       r_out_vld;
    logic                       n_out_vld;
    logic signed [DATA_W-1:0]   r_out;
    logic                       w_out_free;
    logic                       w_fin;
    logic signed [ACC_W-1:0]    w_sum;
    logic signed [QUOT_W-1:0]   w_quot;
    logic signed [BIASED_W-1:0] w_biased;
    logic signed [DATA_W-1:0]   w_clamped;
    logic signed [DATA_W-1:0]   w_act;

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_vld;
    assign o_neuron_out = r_out;

    assign w_out_free = ~r_out_vld | ~i_stall;
    assign o_pop      = ~i_qstat.empty & (~i_head.last | w_out_free);
    assign w_fin      = o_pop & i_head.last;

    // floor divide by 128 is the arithmetic shift, i.e. the upper bits
    assign w_sum    = r_acc + ACC_W'(i_head.prod);
    assign w_quot   = w_sum[ACC_W-1:REQ_SHIFT];
    assign w_biased = BIASED_W'(w_quot) + BIASED_W'(i_head.bias);

    always_comb begin
        if (w_biased > BIASED_W'(OUT_MAX)) begin
            w_clamped = OUT_MAX;
        end else if (w_biased < BIASED_W'(OUT_MIN)) begin
            w_clamped = OUT_MIN;
        end else begin
            w_clamped = w_biased[DATA_W-1:0];
        end
    end

    always_comb begin
        case (r_mode)
            MODE_RELU: begin
                w_act = w_clamped[DATA_W-1] ? '0 : w_clamped;
            end
            MODE_SIGN: begin
                w_act = w_clamped[DATA_W-1] ? OUT_MIN : OUT_MAX;
            end
            default: begin
                w_act = w_clamped;
            end
        endcase
    end

    always_comb begin
        n_acc     = r_acc;
        n_out_vld = r_out_vld;
        if (o_pop) begin
            n_acc = i_head.last ? '0 : w_sum;
        end
        if (w_out_free) begin
            n_out_vld = w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_LINEAR;
            r_acc     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            r_acc     <= n_acc;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out <= w_act;
        end
    end

`ifndef SYNTH
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> r_out_vld && (r_acc == '0))
        else $error("finished neuron did not present result and clear");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/int8_neuron_mac_activate_top.sv
`default_nettype none
// Registers from input transfer to result valid: front item, queue entry, output.
// Throughput: one element per cycle while o_stall is low, set by the single accumulate adder.
// Queue of QUEUE_DEPTH items decouples input acceptance from the output stall.
// Reset (synchronous, active low) clears accumulator, queue, mode to linear.
// ----------------------------------------------------------------------------
// int8_neuron_mac_activate_top: quantised neuron
// Int8 multiply-accumulate with requantise, bias, clamp and activation.
// ----------------------------------------------------------------------------
module int8_neuron_mac_activate_top #(
    parameter int QUEUE_DEPTH = nma_pkg::NMA_QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [nma_pkg::DATA_W-1:0] i_weight,
    input  wire logic signed [nma_pkg::DATA_W-1:0] i_in_value,
    input  wire logic signed [nma_pkg::DATA_W-1:0] i_bias,
    input  wire logic                              i_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [nma_pkg::MODE_W-1:0]        i_cfg_data,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [nma_pkg::DATA_W-1:0]      o_neuron_out
);
    import nma_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_item   w_item;
    t_item   w_head;
    t_q_stat w_qstat;

    nma_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_weight   (i_weight),
        .i_in_value (i_in_value),
        .i_bias     (i_bias),
        .i_last     (i_last),
        .o_push     (w_push),
        .o_item     (w_item),
        .i_qstat    (w_qstat)
    );

    nma_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    nma_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_qstat      (w_qstat),
        .o_pop        (w_pop),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_neuron_out (o_neuron_out)
    );

endmodule
`default_nettype wire

FILE: verif/int8_neuron_mac_activate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_neuron_mac_activate_top_tb: self-checking bench for the int8 neuron
// Feeds weight/activation pairs as dot products of mixed length through the
// valid/stall input, with bursty input traffic and a shifting stall pattern
// on the output. Every result is checked against a known table value or an in-bench
// model of the accumulate, requantise, bias, clamp and activation datapath. The mode
// register is rewritten between phases, only when the block is drained.
// ----------------------------------------------------------------------------
module int8_neuron_mac_activate_top_tb;

    import nma_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // undefined code, acts as linear
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 5000;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 250;

    typedef logic signed [DATA_W-1:0] t_q7;
    typedef logic t_bool;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_q7               weight;
        t_q7               in_value;
        t_q7               bias;
        logic              last;
        logic              known;
        t_q7               neuron_out;
    } t_stim_row;

    localparam int NUM_DIRECTED = 21;
    localparam t_stim_row DIRECTED [NUM_DIRECTED] = '{
        // linear
        '{MODE_LINEAR,  8'sd0,    8'sd0,    8'sd0,    1'b1, 1'b1, 8'sd0},
        '{MODE_LINEAR,  8'sd127,  8'sd127,  8'sd127,  1'b1, 1'b1, 8'sd127},
        '{MODE_LINEAR, -8'sd128, -8'sd128,  8'sd127,  1'b1, 1'b1, 8'sd127},
        '{MODE_LINEAR, -8'sd128,  8'sd127, -8'sd128,  1'b1, 1'b1, -8'sd128},
        '{MODE_LINEAR,  8'sd1,   -8'sd1,    8'sd0,    1'b1, 1'b1, -8'sd1},
        '{MODE_LINEAR,  8'sd127, -8'sd128,  8'sd5,    1'b0, 1'b0, 8'sd0},
        '{MODE_LINEAR, -8'sd128, -8'sd128,  8'sd0,    1'b1, 1'b0, 8'sd0},
        // bias on a non-final element must be dropped
        '{MODE_LINEAR,  8'sd0,    8'sd0,    8'sd127,  1'b0, 1'b0, 8'sd0},
        '{MODE_LINEAR,  8'sd0,    8'sd0,    8'sd0,    1'b1, 1'b1, 8'sd0},
        // relu
        '{MODE_RELU,   -8'sd128,  8'sd127, -8'sd128,  1'b1, 1'b1, 8'sd0},
        '{MODE_RELU,    8'sd1,   -8'sd1,    8'sd0,    1'b1, 1'b1, 8'sd0},
        '{MODE_RELU,    8'sd127,  8'sd127,  8'sd127,  1'b1, 1'b1, 8'sd127},
        '{MODE_RELU,    8'sd64,   8'sd6,    8'sd1,    1'b1, 1'b0, 8'sd0},
        // sign
        '{MODE_SIGN,    8'sd0,    8'sd0,    8'sd0,    1'b1, 1'b1, 8'sd127},
        '{MODE_SIGN,    8'sd1,   -8'sd1,    8'sd0,    1'b1, 1'b1, -8'sd128},
        '{MODE_SIGN,   -8'sd128,  8'sd127, -8'sd128,  1'b1, 1'b1, -8'sd128},
        '{MODE_SIGN,    8'sd127,  8'sd127,  8'sd127,  1'b1, 1'b1, 8'sd127},
        // spare code
        '{MODE_SPARE,  -8'sd128,  8'sd127, -8'sd128,  1'b1, 1'b1, -8'sd128},
        '{MODE_SPARE,   8'sd1,   -8'sd1,    8'sd0,    1'b1, 1'b1, -8'sd1},
        '{MODE_SPARE,   8'sd127,  8'sd127,  8'sd127,  1'b1, 1'b1, 8'sd127},
        '{MODE_SPARE,   8'sd100, -8'sd77,   8'sd90,   1'b1, 1'b0, 8'sd0}
    };

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    t_q7               i_weight     = '0;
    t_q7               i_in_value   = '0;
    t_q7               i_bias       = '0;
    logic              i_last       = 1'b0;
    logic              i_cfg_valid  = 1'b0;
    logic              o_cfg_ready;
    logic [MODE_W-1:0] i_cfg_data   = '0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    t_q7               o_neuron_out;

    int8_neuron_mac_activate_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_weight     (i_weight),
        .i_in_value   (i_in_value),
        .i_bias       (i_bias),
        .i_last       (i_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_neuron_out (o_neuron_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model state
    logic signed [ACC_W-1:0] dot_acc   = '0;
    logic [MODE_W-1:0]       act_mode  = MODE_LINEAR;
    t_q7                     pending_neuron_out[$];
    int                      error_count = 0;
    int                      burst_left  = 0;

    task automatic report_mismatch(input string what, input t_q7 got, input t_q7 want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Accumulate one element; on the final element requantise and queue the
    // expected output. A known value from the table overrides the model's.
    task automatic accumulate_element(input t_q7 w, input t_q7 x, input t_q7 b,
                                      input logic lst, input logic known,
                                      input t_q7 known_out);
        logic signed [PROD_W-1:0] prod;
        logic signed [ACC_W-1:0]  quot;
        logic signed [ACC_W:0]    biased;
        t_q7                      res;
        prod    = w * x;
        dot_acc = dot_acc + prod;
        if (lst) begin
            quot   = dot_acc >>> REQ_SHIFT;
            biased = quot + b;
            if (biased > OUT_MAX)
                res = OUT_MAX;
            else if (biased < OUT_MIN)
                res = OUT_MIN;
            else
                res = biased[DATA_W-1:0];
            case (act_mode)
                MODE_RELU: if (res < 0) res = '0;
                MODE_SIGN: res = (res < 0) ? OUT_MIN : OUT_MAX;
                default: ;
            endcase
            dot_acc = '0;
            pending_neuron_out.push_back(known ? known_out : res);
        end
    endtask

    task automatic send_element(input t_q7 w, input t_q7 x, input t_q7 b, input logic lst,
                                input logic known, input t_q7 known_out);
        i_valid    <= 1'b1;
        i_weight   <= w;
        i_in_value <= x;
        i_bias     <= b;
        i_last     <= lst;
        do @(posedge i_clk); while (o_stall);
        accumulate_element(w, x, b, lst, known, known_out);
    endtask

    // Burst/gap pacing on the input side; junk on the payload while idle.
    task automatic pace_input();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid    <= 1'b0;
            i_weight   <= t_q7'($urandom);
            i_in_value <= t_q7'($urandom);
            i_bias     <= t_q7'($urandom);
            i_last     <= 1'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        while (pending_neuron_out.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        act_mode = mode;
    endtask

    function automatic t_q7 rand_q7();
        case ($urandom_range(0, 3))
            0: return t_q7'(int'($urandom_range(0, 16)) - 8);
            1: return $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
            default: return t_q7'($urandom);
        endcase
    endfunction

    // Output side: check each transfer, then pick the next stall.
    int stall_style = 0;
    int style_left  = 0;

    always @(posedge i_clk) begin : out_side
        t_q7 want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_neuron_out.size() == 0) begin
                report_mismatch("unexpected neuron_out", o_neuron_out, '0);
            end else begin
                want = pending_neuron_out.pop_front();
                if (o_neuron_out !== want)
                    report_mismatch("neuron_out", o_neuron_out, want);
            end
        end
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 200);
        end else begin
            style_left--;
        end
        case (stall_style)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 4);
            2: i_stall <= ~i_stall;
            default: i_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int               left;
        int               seq_len;
        t_bool            paused;
        logic [MODE_W-1:0] phase_mode;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].mode != act_mode)
                write_mode(DIRECTED[r].mode);
            send_element(DIRECTED[r].weight, DIRECTED[r].in_value, DIRECTED[r].bias,
                         DIRECTED[r].last, DIRECTED[r].known, DIRECTED[r].neuron_out);
            pace_input();
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: phase_mode = MODE_LINEAR;
                1: phase_mode = MODE_SIGN;
                2: phase_mode = MODE_RELU;
                3: phase_mode = MODE_SPARE;
                default: phase_mode = MODE_W'($urandom_range(0, 3));
            endcase
            write_mode(phase_mode);
            left   = PHASE_ITEMS;
            paused = 1'b0;
            while (left > 0) begin
                case ($urandom_range(0, 19))
                    0: seq_len = $urandom_range(65, 300);
                    1, 2, 3, 4: seq_len = $urandom_range(9, 64);
                    default: seq_len = $urandom_range(1, 8);
                endcase
                if (seq_len > left)
                    seq_len = left;
                for (int k = 0; k < seq_len; k++) begin
                    send_element(rand_q7(), rand_q7(), t_q7'($urandom),
                                 k == seq_len - 1, 1'b0, '0);
                    pace_input();
                end
                left -= seq_len;
                if (!paused && left < PHASE_ITEMS / 2) begin
                    hold_until_drained();
                    paused = 1'b1;
                end
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/nma_pkg.sv
hw/rtl/nma_front.sv
hw/rtl/nma_queue.sv
hw/rtl/nma_back.sv
hw/rtl/int8_neuron_mac_activate_top.sv
verif/int8_neuron_mac_activate_top_tb.sv
